>>> src/rtoh_pkg.sv
// rtoh_pkg: widths and stage types for the rgb to hsv pixel converter
// no dependencies; used by all modules in src
package rtoh_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;
    localparam int DEN_BITS      = CHANNEL_BITS + 3;

    typedef struct packed {
        logic [DEN_BITS-1:0]      rem;
        logic [DEN_BITS-1:0]      den;
        logic [FRACTION_BITS-1:0] quo;
    } t_lane;

    typedef struct packed {
        t_lane                   hue;
        t_lane                   sat;
        logic [CHANNEL_BITS-1:0] value;
        logic                    hue_zero;
        logic                    sat_zero;
        logic                    sat_full;
    } t_stage;

endpackage

>>> src/rtoh_front.sv
// rtoh_front: max, min, chroma and hue numerator of one pixel, registered
// depends on rtoh_pkg
module rtoh_front import rtoh_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    output t_stage                  o_stage
);

    logic [CHANNEL_BITS-1:0] w_max;
    logic [CHANNEL_BITS-1:0] w_min;
    logic [CHANNEL_BITS-1:0] w_chr;
    logic [DEN_BITS-1:0]     w_chr_x;
    logic [DEN_BITS-1:0]     w_num;
    t_stage                  n_stage;
    logic                    r_valid;
    t_stage                  r_stage;

    always_comb begin
        w_max = (i_red > i_green) ? i_red : i_green;
        if (i_blue > w_max) begin
            w_max = i_blue;
        end
        w_min = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_min) begin
            w_min = i_blue;
        end
        w_chr   = w_max - w_min;
        w_chr_x = DEN_BITS'(w_chr);
        if (w_max == i_red) begin
            if (i_green >= i_blue) begin
                w_num = DEN_BITS'(i_green) - DEN_BITS'(i_blue);
            end else begin
                w_num = (w_chr_x << 2) + (w_chr_x << 1)
                        - (DEN_BITS'(i_blue) - DEN_BITS'(i_green));
            end
        end else if (w_max == i_green) begin
            w_num = (w_chr_x << 1) + DEN_BITS'(i_blue) - DEN_BITS'(i_red);
        end else begin
            w_num = (w_chr_x << 2) + DEN_BITS'(i_red) - DEN_BITS'(i_green);
        end
        n_stage.hue.rem  = w_num;
        n_stage.hue.den  = (w_chr_x << 2) + (w_chr_x << 1);
        n_stage.hue.quo  = '0;
        n_stage.sat.rem  = w_chr_x;
        n_stage.sat.den  = DEN_BITS'(w_max);
        n_stage.sat.quo  = '0;
        n_stage.value    = w_max;
        n_stage.hue_zero = (w_chr == '0);
        n_stage.sat_zero = (w_max == '0);
        n_stage.sat_full = (w_min == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> src/rtoh_cell.sv
// rtoh_cell: one restoring division step for the hue and saturation lanes
// depends on rtoh_pkg
module rtoh_cell import rtoh_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_stage o_stage
);

    logic [DEN_BITS:0] w_hue_two;
    logic [DEN_BITS:0] w_sat_two;
    t_stage            n_stage;
    logic              r_valid;
    t_stage            r_stage;

    always_comb begin
        n_stage   = i_stage;
        w_hue_two = {i_stage.hue.rem, 1'b0};
        w_sat_two = {i_stage.sat.rem, 1'b0};
        if (w_hue_two >= {1'b0, i_stage.hue.den}) begin
            n_stage.hue.rem = DEN_BITS'(w_hue_two - {1'b0, i_stage.hue.den});
            n_stage.hue.quo = {i_stage.hue.quo[FRACTION_BITS-2:0], 1'b1};
        end else begin
            n_stage.hue.rem = DEN_BITS'(w_hue_two);
            n_stage.hue.quo = {i_stage.hue.quo[FRACTION_BITS-2:0], 1'b0};
        end
        if (w_sat_two >= {1'b0, i_stage.sat.den}) begin
            n_stage.sat.rem = DEN_BITS'(w_sat_two - {1'b0, i_stage.sat.den});
            n_stage.sat.quo = {i_stage.sat.quo[FRACTION_BITS-2:0], 1'b1};
        end else begin
            n_stage.sat.rem = DEN_BITS'(w_sat_two);
            n_stage.sat.quo = {i_stage.sat.quo[FRACTION_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> src/rgb_to_hsv_pixel.sv
// rgb_to_hsv_pixel: top level of the rgb to hsv pixel converter
// depends on rtoh_pkg, rtoh_front and rtoh_cell
//
// usage:
//   input channel i_valid / o_stall carries one pixel item (i_red, i_green,
//   i_blue); output channel o_valid / i_stall carries o_hue, o_saturation
//   and o_value. an item moves when valid is high and stall is low.
//   one front stage finds max, min and chroma, then a row of FRACTION_BITS
//   division cells each produces one quotient bit of hue and of saturation.
//   an item passes the front register and then each cell in turn before its
//   result appears; one item is taken per cycle while o_stall is low.
//   the last cell holds the result; while i_stall holds it the whole row
//   freezes and o_stall goes high, and it releases in the cycle that the
//   result is taken.
//   synchronous active-low reset clears all valid bits; no item is in
//   flight afterwards. payload registers are not reset.
module rgb_to_hsv_pixel import rtoh_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CHANNEL_BITS-1:0]  i_red,
    input  logic [CHANNEL_BITS-1:0]  i_green,
    input  logic [CHANNEL_BITS-1:0]  i_blue,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [FRACTION_BITS-1:0] o_hue,
    output logic [FRACTION_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0]  o_value
);

    logic                w_en;
    logic   [FRACTION_BITS:0] w_valid;
    t_stage [FRACTION_BITS:0] w_stage;
    t_stage              w_last;

    assign w_en    = !(w_valid[FRACTION_BITS] && i_stall);
    assign o_stall = !w_en;

    rtoh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_valid[0]),
        .o_stage (w_stage[0])
    );

    for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_cell
        rtoh_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    assign w_last  = w_stage[FRACTION_BITS];
    assign o_valid = w_valid[FRACTION_BITS];
    assign o_value = w_last.value;
    assign o_hue   = w_last.hue_zero ? '0 : w_last.hue.quo;

    always_comb begin
        if (w_last.sat_zero) begin
            o_saturation = '0;
        end else if (w_last.sat_full) begin
            o_saturation = '1;
        end else begin
            o_saturation = w_last.sat.quo;
        end
    end

    a_black_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_value == '0) |-> (o_saturation == '0) && (o_hue == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_gray_hue_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_saturation == '0) |-> (o_hue == '0))
        else $error("gray pixel with nonzero hue");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule
